/* rtl/core/sfr_pkg.sv */
// Shared types, character codes and the CRC-16 byte update for the stuffed frame receiver.
package sfr_pkg;

  localparam int MaxFrame = 256;
  localparam int CntW     = $clog2(MaxFrame + 2);
  localparam int LenSat   = 256;

  localparam logic [15:0] TimeoutReset = 16'd1000;
  localparam logic [15:0] CrcPoly      = 16'h1021;

  localparam logic [7:0] ChDle = 8'h05;
  localparam logic [7:0] ChStx = 8'h55;
  localparam logic [7:0] ChEtx = 8'h04;

  typedef enum logic [1:0] {
    KindPayload = 2'd0,
    KindStatus  = 2'd1,
    KindAbort   = 2'd2
  } kind_e;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] payload_byte;
    logic [8:0] frame_length;
    logic       crc_ok;
    logic       length_ok;
    logic       overflow;
  } out_word_t;

  // Word as it sits in the queue, already classified by the front end.
  typedef struct packed {
    logic       is_tick;
    logic       is_stx;
    logic       is_dle;
    logic       is_etx;
    logic [7:0] data;
  } item_t;

  // Handshake between the queue and the back end.
  typedef struct packed {
    logic avail;
    logic take;
  } q_ctrl_t;

  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

/* rtl/core/stuffed_frame_receiver_crc16_core.sv */
// Stuffed frame receiver: byte-stuffed frame decoding with a CRC-16 check.
// Throughput: one word per cycle while the output is not stalled, set by the back end step.
// A word accepted at an edge is written into the queue; the back end takes it from there once
// the output register is free, and its result is then held in the output register.
// The two-entry queue stalls the input only when full; the back end stalls only on out_stall_i.
// Reset: asynchronous, active low; the block comes up idle with timeout_q at 1000.
module stuffed_frame_receiver_crc16_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sfr_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sfr_pkg::out_word_t out_word_o,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i
);
  import sfr_pkg::*;

  logic    q_full;
  logic    q_push;
  logic    q_avail;
  logic [1:0] q_level;
  item_t   front_item;
  item_t   back_item;
  q_ctrl_t q_ctrl;

  sfr_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .item_o     (front_item)
  );

  sfr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (front_item),
    .full_o  (q_full),
    .level_o (q_level),
    .take_i  (q_ctrl.take),
    .avail_o (q_avail),
    .item_o  (back_item)
  );

  sfr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_ctrl_o    (q_ctrl),
    .q_avail_i   (q_avail),
    .item_i      (back_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // The queue never holds more than its two entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_level != 2'd3)
    else $error("queue level out of range");

  // The back end only pops an item that is present.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_ctrl.take |-> q_ctrl.avail)
    else $error("pop from empty queue");

  // Status fields are zero on every word that is not a frame end status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && (out_word_o.kind != KindStatus) |->
      (out_word_o.frame_length == 9'd0) && !out_word_o.crc_ok &&
      !out_word_o.length_ok && !out_word_o.overflow)
    else $error("status fields set on a non-status word");

  // A frame that overflowed never passes the length check.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && out_word_o.overflow |-> !out_word_o.length_ok &&
      (out_word_o.frame_length == 9'(LenSat)))
    else $error("overflowed frame reported with a valid length");

endmodule

/* rtl/core/sfr_front.sv */
// Front end: accepts input words and classifies them into queue items.
module sfr_front (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sfr_pkg::in_word_t in_word_i,
  input  logic              q_full_i,
  output logic              push_o,
  output sfr_pkg::item_t    item_o
);
  import sfr_pkg::*;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    item_o.is_tick = in_word_i.op;
    item_o.data    = in_word_i.rx_byte;
    item_o.is_stx  = !in_word_i.op && (in_word_i.rx_byte == ChStx);
    item_o.is_dle  = !in_word_i.op && (in_word_i.rx_byte == ChDle);
    item_o.is_etx  = !in_word_i.op && (in_word_i.rx_byte == ChEtx);
  end

endmodule

/* rtl/core/sfr_queue.sv */
// Two-entry queue that decouples the front end from the back end.
module sfr_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sfr_pkg::item_t    item_i,
  output logic              full_o,
  output logic [1:0]        level_o,
  input  logic              take_i,
  output logic              avail_o,
  output sfr_pkg::item_t    item_o
);
  import sfr_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign avail_o = (count_q != 2'd0);
  assign level_o = count_q;
  assign item_o  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = take_i && avail_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

/* rtl/core/sfr_back.sv */
// Back end: framing state machine, CRC, status generation and the output register.
module sfr_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  output sfr_pkg::q_ctrl_t   q_ctrl_o,
  input  logic               q_avail_i,
  input  sfr_pkg::item_t     item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sfr_pkg::out_word_t out_word_o
);
  import sfr_pkg::*;

  typedef enum logic [2:0] {
    ModeIdle  = 3'b001,
    ModeHunt  = 3'b010,
    ModeFrame = 3'b100
  } mode_e;

  mode_e            mode_q, mode_d;
  logic             esc_q, esc_d;
  logic [15:0]      ticks_q, ticks_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [15:0]      hold_q, hold_d;
  logic [15:0]      crc_q, crc_d;
  logic [15:0]      size_q, size_d;
  logic             ovf_q, ovf_d;
  logic [15:0]      timeout_q;
  logic             out_valid_q, out_valid_d;
  out_word_t        out_word_q, out_word_d;

  logic             take;
  logic             in_frame;
  logic [15:0]      ticks_inc;
  logic [15:0]      limit;

  // The output register frees up either when empty or when its word is taken now.
  assign take           = q_avail_i && (!out_valid_q || !out_stall_i);
  assign q_ctrl_o.avail = q_avail_i;
  assign q_ctrl_o.take  = take;

  assign in_frame  = (mode_q == ModeFrame);
  assign ticks_inc = (ticks_q == 16'hFFFF) ? ticks_q : ticks_q + 16'd1;
  assign limit     = (timeout_q == 16'd0) ? 16'd1 : timeout_q;

  always_comb begin
    mode_d      = mode_q;
    esc_d       = esc_q;
    ticks_d     = ticks_q;
    count_d     = count_q;
    hold_d      = hold_q;
    crc_d       = crc_q;
    size_d      = size_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_word_d  = out_word_q;

    if (take) begin
      out_valid_d = 1'b0;
      out_word_d  = '0;
      if (item_i.is_tick) begin
        unique case (mode_q) inside
          ModeHunt, ModeFrame: begin
            if (ticks_inc >= limit) begin
              if (in_frame) begin
                out_valid_d     = 1'b1;
                out_word_d.kind = KindAbort;
              end
              mode_d  = ModeIdle;
              esc_d   = 1'b0;
              ticks_d = 16'd0;
            end else begin
              ticks_d = ticks_inc;
            end
          end
          default: begin
            // Ticks are ignored while idle; an unknown mode settles to idle.
            mode_d = ModeIdle;
          end
        endcase
      end else begin
        ticks_d = 16'd0;
        if (!in_frame) begin
          if (item_i.is_stx) begin
            mode_d  = ModeFrame;
            esc_d   = 1'b0;
            count_d = '0;
            hold_d  = 16'd0;
            crc_d   = 16'd0;
            size_d  = 16'd0;
            ovf_d   = 1'b0;
          end else begin
            mode_d = ModeHunt;
          end
        end else if (!esc_q && item_i.is_dle) begin
          esc_d = 1'b1;
        end else if (!esc_q && item_i.is_etx) begin
          out_valid_d             = 1'b1;
          out_word_d.kind         = KindStatus;
          out_word_d.frame_length = (count_q > CntW'(LenSat)) ? 9'(LenSat) : 9'(count_q);
          out_word_d.crc_ok       = (count_q >= CntW'(2)) && (crc_q == hold_q);
          out_word_d.length_ok    = !ovf_q && (17'(count_q) == 17'(size_q) + 17'd5);
          out_word_d.overflow     = ovf_q;
          mode_d                  = ModeIdle;
          esc_d                   = 1'b0;
        end else begin
          // Data word: the byte two places back leaves, so the trailing CRC never does.
          esc_d = 1'b0;
          if (count_q >= CntW'(2)) begin
            crc_d                   = crc16_byte(crc_q, hold_q[15:8]);
            out_valid_d             = 1'b1;
            out_word_d.kind         = KindPayload;
            out_word_d.payload_byte = hold_q[15:8];
          end
          if (count_q == CntW'(1)) begin
            size_d = {item_i.data, 8'h00};
          end else if (count_q == CntW'(2)) begin
            size_d = {size_q[15:8], item_i.data};
          end
          hold_d = {hold_q[7:0], item_i.data};
          if (count_q >= CntW'(MaxFrame)) begin
            ovf_d = 1'b1;
          end
          if (count_q <= CntW'(MaxFrame)) begin
            count_d = count_q + CntW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeIdle;
      esc_q       <= 1'b0;
      ticks_q     <= 16'd0;
      count_q     <= '0;
      hold_q      <= 16'd0;
      crc_q       <= 16'd0;
      size_q      <= 16'd0;
      ovf_q       <= 1'b0;
      timeout_q   <= TimeoutReset;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      esc_q       <= esc_d;
      ticks_q     <= ticks_d;
      count_q     <= count_d;
      hold_q      <= hold_d;
      crc_q       <= crc_d;
      size_q      <= size_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

/* tb/sv/stuffed_frame_receiver_crc16_core_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the stuffed frame receiver core with its CRC-16 check.
module stuffed_frame_receiver_crc16_core_test;
  import sfr_pkg::*;

  localparam logic OpByte = 1'b0;
  localparam logic OpTick = 1'b1;

  localparam int HoldCycles   = 300;
  localparam int QuietLimit   = 3000;
  localparam int SettleCycles = 4;

  typedef enum logic [1:0] {
    RxIdle,
    RxHunt,
    RxFrame
  } rx_mode_e;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_word_t    in_word_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_word_t   out_word_o;
  logic        cfg_we_i    = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  stuffed_frame_receiver_crc16_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Deframer state mirrored by the testbench.
  rx_mode_e    rx_mode     = RxIdle;
  logic        esc_pending = 1'b0;
  int unsigned tick_run    = 0;
  int unsigned frame_bytes = 0;
  logic [15:0] held        = '0;
  logic [15:0] crc_run     = '0;
  logic [15:0] size_fld    = '0;
  logic        ovf         = 1'b0;
  logic [15:0] timeout_cfg = TimeoutReset;
  out_word_t   deframed_q[$];

  int mismatch_cnt = 0;
  int words_sent   = 0;
  int burst_left   = 0;
  int quiet_cycles = 0;
  bit hold_req     = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0};
      if (fb) c = c ^ CrcPoly;
    end
    return c;
  endfunction

  // Advances the mirrored deframer by one accepted word and queues what it yields.
  function automatic void deframe_word(in_word_t w);
    out_word_t   r;
    bit          emit;
    int unsigned lim;
    r    = '0;
    emit = 1'b0;
    if (w.op == OpTick) begin
      if (rx_mode == RxIdle) return;
      if (tick_run < 16'hFFFF) tick_run++;
      lim = (timeout_cfg == 0) ? 1 : timeout_cfg;
      if (tick_run >= lim) begin
        if (rx_mode == RxFrame) begin
          r.kind = KindAbort;
          emit   = 1'b1;
        end
        rx_mode     = RxIdle;
        esc_pending = 1'b0;
        tick_run    = 0;
      end
    end else begin
      tick_run = 0;
      if (rx_mode != RxFrame) begin
        if (w.rx_byte == ChStx) begin
          rx_mode     = RxFrame;
          esc_pending = 1'b0;
          frame_bytes = 0;
          held        = '0;
          crc_run     = '0;
          size_fld    = '0;
          ovf         = 1'b0;
        end else begin
          rx_mode = RxHunt;
        end
      end else if (!esc_pending && w.rx_byte == ChDle) begin
        esc_pending = 1'b1;
      end else if (!esc_pending && w.rx_byte == ChEtx) begin
        r.kind         = KindStatus;
        r.frame_length = (frame_bytes > LenSat) ? 9'(LenSat) : 9'(frame_bytes);
        r.crc_ok       = (frame_bytes >= 2) && (crc_run == held);
        r.length_ok    = !ovf && (frame_bytes == size_fld + 32'd5);
        r.overflow     = ovf;
        emit           = 1'b1;
        rx_mode        = RxIdle;
        esc_pending    = 1'b0;
      end else begin
        esc_pending = 1'b0;
        // The two newest bytes are held back; only older ones leave and feed the CRC.
        if (frame_bytes >= 2) begin
          crc_run        = crc16_update(crc_run, held[15:8]);
          r.kind         = KindPayload;
          r.payload_byte = held[15:8];
          emit           = 1'b1;
        end
        if (frame_bytes == 1) size_fld = {w.rx_byte, 8'h00};
        else if (frame_bytes == 2) size_fld[7:0] = w.rx_byte;
        held = {held[7:0], w.rx_byte};
        if (frame_bytes >= MaxFrame) ovf = 1'b1;
        if (frame_bytes <= MaxFrame) frame_bytes++;
      end
    end
    if (emit) deframed_q.push_back(r);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: %s: got %0h, want %0h", $realtime, what, got, want);
    mismatch_cnt++;
  endtask

  // Sends one word in bursts with random gaps in between.
  task automatic send_word(logic op, logic [7:0] b);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 2) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_word_i  <= '{op: op, rx_byte: b};
    do @(posedge clk_i); while (in_stall_o);
    deframe_word('{op: op, rx_byte: b});
    words_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_word(OpByte, b);
  endtask

  task automatic send_tick();
    send_word(OpTick, 8'($urandom));
  endtask

  // Stops sending until every queued result has come out, then lets the pipe settle.
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (deframed_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_timeout(logic [15:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    timeout_cfg = v;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 11))
      0:       return ChDle;
      1:       return ChEtx;
      2:       return ChStx;
      default: return 8'($urandom);
    endcase
  endfunction

  // Builds a frame of size field, body and CRC, stuffs it and sends it with optional ticks.
  task automatic send_frame(int body_len, bit crc_good, bit len_good, int esc_pct,
                            int tick_max, bit close);
    logic [7:0]  data[$];
    logic [7:0]  raw[$];
    logic [15:0] crc;
    logic [15:0] size;
    size = len_good ? 16'(body_len - 1) : 16'($urandom);
    data.push_back(size[15:8]);
    data.push_back(size[7:0]);
    repeat (body_len) data.push_back(pick_byte());
    crc = '0;
    foreach (data[i]) crc = crc16_update(crc, data[i]);
    if (!crc_good) crc = crc ^ (16'd1 << $urandom_range(0, 15));
    data.push_back(crc[15:8]);
    data.push_back(crc[7:0]);
    raw.push_back(ChStx);
    foreach (data[i]) begin
      if (data[i] == ChDle || data[i] == ChEtx || $urandom_range(0, 99) < esc_pct)
        raw.push_back(ChDle);
      raw.push_back(data[i]);
    end
    if (close) raw.push_back(ChEtx);
    foreach (raw[i]) begin
      if (tick_max > 0 && $urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, tick_max)) send_tick();
      send_byte(raw[i]);
    end
  endtask

  task automatic test_basic_frames();
    send_word(OpTick, ChStx);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_tick();
    send_byte(ChStx);
    send_byte(ChEtx);
    send_byte(ChStx);
    send_byte(ChDle);
    send_byte(ChEtx);
    send_byte(ChEtx);
    send_byte(ChStx);
    send_byte(ChDle);
    send_byte(ChDle);
    send_byte(ChStx);
    send_byte(ChDle);
    send_byte(8'hAB);
    send_byte(ChEtx);
    send_frame(1, 1'b1, 1'b1, 0, 0, 1'b1);
    wait_quiet();
  endtask

  task automatic test_timeouts();
    set_timeout(16'd1);
    send_byte(ChStx);
    send_word(OpTick, ChEtx);
    send_byte(8'h20);
    send_tick();
    send_tick();
    wait_quiet();
    // Zero behaves as one tick; a pending escape must not survive the abort.
    set_timeout(16'd0);
    send_byte(ChStx);
    send_byte(ChDle);
    send_tick();
    send_byte(ChEtx);
    send_tick();
    wait_quiet();
    set_timeout(16'd3);
    send_byte(ChStx);
    send_byte(8'h10);
    send_tick();
    send_tick();
    send_byte(8'h11);
    send_tick();
    send_tick();
    send_byte(ChEtx);
    wait_quiet();
    set_timeout(16'hFFFF);
    send_byte(ChStx);
    repeat (40) send_tick();
    send_byte(ChEtx);
    wait_quiet();
  endtask

  // Frames of exactly the maximum size and one byte beyond it.
  task automatic test_frame_limits();
    send_frame(MaxFrame - 4, 1'b1, 1'b1, 0, 0, 1'b1);
    send_frame(MaxFrame - 3, 1'b1, 1'b1, 0, 0, 1'b1);
    wait_quiet();
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    send_frame(40, 1'b1, 1'b1, 5, 0, 1'b1);
    wait_quiet();
  endtask

  task automatic test_random_traffic(logic [15:0] ticks_limit, int count);
    int goal;
    int pick;
    int tick_max;
    int tick_cap;
    set_timeout(ticks_limit);
    goal     = words_sent + count;
    tick_cap = (ticks_limit < 8) ? int'(ticks_limit) + 1 : 8;
    while (words_sent < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        tick_max = ($urandom_range(0, 3) == 0) ? int'(ticks_limit) : int'(ticks_limit) - 1;
        if (tick_max > 8) tick_max = 8;
        if (tick_max < 0) tick_max = 0;
        send_frame(($urandom_range(0, 7) == 0) ? $urandom_range(17, 48) : $urandom_range(0, 16),
                   $urandom_range(0, 99) < 85, $urandom_range(0, 99) < 85, 10, tick_max,
                   $urandom_range(0, 9) != 0);
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 3) == 0) send_tick();
          else send_byte(pick_byte());
        end
      end else begin
        repeat ($urandom_range(1, tick_cap)) send_tick();
      end
    end
    wait_quiet();
  endtask

  // Output stall pattern, with a long hold-off on request.
  int   stall_mode = 0;
  int   stall_left = 0;
  logic stall_flip = 1'b0;
  always begin
    @(posedge clk_i);
    if (hold_req) begin
      hold_req = 1'b0;
      out_stall_i <= 1'b1;
      repeat (HoldCycles) @(posedge clk_i);
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(5, 60);
    end
    stall_left--;
    stall_flip = ~stall_flip;
    case (stall_mode)
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      2:       out_stall_i <= ($urandom_range(0, 9) < 7);
      3:       out_stall_i <= stall_flip;
      default: out_stall_i <= 1'b0;
    endcase
  end

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (deframed_q.size() == 0) begin
        report_mismatch("word with nothing pending, kind", out_word_o.kind, 0);
      end else begin
        want = deframed_q.pop_front();
        if (out_word_o.kind != want.kind)
          report_mismatch("kind", out_word_o.kind, want.kind);
        if (out_word_o.payload_byte != want.payload_byte)
          report_mismatch("payload_byte", out_word_o.payload_byte, want.payload_byte);
        if (out_word_o.frame_length != want.frame_length)
          report_mismatch("frame_length", out_word_o.frame_length, want.frame_length);
        if (out_word_o.crc_ok != want.crc_ok)
          report_mismatch("crc_ok", out_word_o.crc_ok, want.crc_ok);
        if (out_word_o.length_ok != want.length_ok)
          report_mismatch("length_ok", out_word_o.length_ok, want.length_ok);
        if (out_word_o.overflow != want.overflow)
          report_mismatch("overflow", out_word_o.overflow, want.overflow);
      end
    end
  end

  // Ends the run when neither side moves a word for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_frames();
    test_timeouts();
    test_frame_limits();
    test_backpressure();
    test_random_traffic(16'd4, 50);
    test_random_traffic(16'd1, 40);
    test_random_traffic(16'd1000, 50);
    if (deframed_q.size() != 0)
      report_mismatch("results never delivered", 0, deframed_q.size());
    if (mismatch_cnt == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
